// File: design/hlc_pkg.sv
// ----------------------------------------------------------------------------
// hlc_pkg: shared types and constants for the hopper leg controller
// Request payload structs, register indexes, CORDIC table, controller states.
// ----------------------------------------------------------------------------
package hlc_pkg;

  typedef struct packed {
    logic signed [31:0] spring_pos;
    logic signed [31:0] spring_rate;
    logic signed [31:0] hinge_angle;
    logic signed [31:0] hinge_rate;
    logic signed [31:0] forward_vel;
    logic signed [31:0] dip_vertical;
    logic signed [31:0] dip_along;
    logic signed [31:0] foot_height;
    logic               jump_toggle;
  } hlc_in_t;

  typedef struct packed {
    logic signed [31:0] spring_force;
    logic signed [31:0] hinge_torque;
    logic               on_ground;
    logic [15:0]        phase_ticks;
    logic               jump_active;
  } hlc_out_t;

  localparam int REG_COUNT = 8;
  typedef enum logic [2:0] {
    REG_PUSH_OFFSET = 3'd0, REG_SPRING_K = 3'd1, REG_SPRING_D = 3'd2,
    REG_SPEED = 3'd3, REG_SWING_KP = 3'd4, REG_SWING_KD = 3'd5,
    REG_STANCE_KP = 3'd6, REG_STANCE_KD = 3'd7
  } hlc_reg_t;

  localparam int          ANG_BITS     = 30;
  localparam int          CORDIC_STEPS = 31;
  localparam logic [63:0] PI_Q30       = 64'd3373259426;
  localparam logic [63:0] LEG_Q30      = 64'd343597384;
  localparam logic [63:0] REST_Q30     = 64'd107374182;
  localparam logic [63:0] PUSH_LIM_Q30 = 64'd214748365;
  localparam logic [63:0] AIM_GAIN_Q30 = 64'd2684355;
  localparam logic [63:0] SPD_GAIN_Q30 = 64'd53687091;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_NORM1, ST_CORDIC1, ST_AIM, ST_SQRT, ST_NORM2,
    ST_CORDIC2, ST_LAW, ST_MUL, ST_DONE
  } hlc_state_t;

  typedef struct packed {
    logic load;
    logic prep1;
    logic norm;
    logic cordic;
    logic aim;
    logic sqrt_step;
    logic prep2;
    logic law;
    logic mul_step;
    logic finish;
  } hlc_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic cordic_done;
    logic sqrt_done;
    logic mul_done;
  } hlc_stat_t;

  function automatic logic signed [63:0] atan_entry(input logic [4:0] i);
    logic signed [63:0] v;
    case (i)
      5'd0: v = 64'sd843314856;  5'd1: v = 64'sd497837829;
      5'd2: v = 64'sd263043836;  5'd3: v = 64'sd133525158;
      5'd4: v = 64'sd67021686;   5'd5: v = 64'sd33543515;
      5'd6: v = 64'sd16775850;   5'd7: v = 64'sd8388437;
      5'd8: v = 64'sd4194282;    5'd9: v = 64'sd2097149;
      5'd10: v = 64'sd1048575;   5'd11: v = 64'sd524287;
      5'd12: v = 64'sd262143;    5'd13: v = 64'sd131071;
      5'd14: v = 64'sd65535;     5'd15: v = 64'sd32767;
      5'd16: v = 64'sd16383;     5'd17: v = 64'sd8191;
      5'd18: v = 64'sd4095;      5'd19: v = 64'sd2047;
      5'd20: v = 64'sd1023;      5'd21: v = 64'sd511;
      5'd22: v = 64'sd255;       5'd23: v = 64'sd127;
      5'd24: v = 64'sd63;        5'd25: v = 64'sd31;
      5'd26: v = 64'sd15;        5'd27: v = 64'sd8;
      5'd28: v = 64'sd4;         5'd29: v = 64'sd2;
      5'd30: v = 64'sd1;
      default: v = 64'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

endpackage

// File: design/hopper_leg_controller_core.sv
// Sequence from accept to out_valid: two 31-step CORDIC passes with
//   prescaling, a bit-pair isqrt, four products on one shared multiplier
//   and the single-state steps between them.
// One request at a time: the next is taken once the result is loaded into
//   the output register.
// Reset: synchronous active-low rst_n clears the sequencer, tick history
//   (angle, contact, phase count, jump mode/timer) and loads register defaults.
// ----------------------------------------------------------------------------
// hopper_leg_controller_core: one-leg hopper control law, one tick per request
// Controller sequencer plus arithmetic datapath, with an output register.
// ----------------------------------------------------------------------------
module hopper_leg_controller_core #(
  parameter int FRAC_BITS        = 16,
  parameter int COUNT_BITS       = 16,
  parameter int STEPS_PER_SECOND = 60
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hlc_pkg::hlc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output hlc_pkg::hlc_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import hlc_pkg::*;

  hlc_cmd_t  cmd;
  hlc_stat_t stat;
  hlc_out_t  res;
  logic      busy, out_valid_r, out_free;
  hlc_out_t  out_r;

  // output register is free when empty or being drained this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = busy;
  assign cfg_ready = 1'b1;

  hlc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(in_valid), .out_free(out_free),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  hlc_datapath #(
    .FRAC_BITS(FRAC_BITS), .COUNT_BITS(COUNT_BITS),
    .STEPS_PER_SECOND(STEPS_PER_SECOND)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_req(in_data),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg_we(cfg_valid),
    .stat(stat), .result(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.finish) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !(in_valid && !in_stall)) else $error("accept while busy");
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> out_free) else $error("result overwrite");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> busy) else $error("load did not start tick");
endmodule

// File: design/hlc_ctrl.sv
// ----------------------------------------------------------------------------
// hlc_ctrl: sequencer for one control tick
// Steps the datapath through both atan2 passes, the isqrt and the gain products.
// ----------------------------------------------------------------------------
module hlc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             out_free,
  input  hlc_pkg::hlc_stat_t stat,
  output hlc_pkg::hlc_cmd_t  cmd,
  output logic             busy
);
  import hlc_pkg::*;

  hlc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (start) state_nxt = ST_PREP;
      ST_PREP:    state_nxt = ST_NORM1;
      ST_NORM1:   if (stat.norm_done) state_nxt = ST_CORDIC1;
      ST_CORDIC1: if (stat.cordic_done) state_nxt = ST_AIM;
      ST_AIM:     state_nxt = ST_SQRT;
      ST_SQRT:    if (stat.sqrt_done) state_nxt = ST_NORM2;
      ST_NORM2:   if (stat.norm_done) state_nxt = ST_CORDIC2;
      ST_CORDIC2: if (stat.cordic_done) state_nxt = ST_LAW;
      ST_LAW:     state_nxt = ST_MUL;
      ST_MUL:     if (stat.mul_done) state_nxt = ST_DONE;
      ST_DONE:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE:    cmd.load = start;
      ST_PREP:    cmd.prep1 = 1'b1;
      ST_NORM1:   cmd.norm = 1'b1;
      ST_CORDIC1: cmd.cordic = 1'b1;
      ST_AIM:     cmd.aim = 1'b1;
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cmd.prep2 = stat.sqrt_done;
      end
      ST_NORM2:   cmd.norm = 1'b1;
      ST_CORDIC2: cmd.cordic = 1'b1;
      ST_LAW:     cmd.law = 1'b1;
      ST_MUL:     cmd.mul_step = 1'b1;
      ST_DONE:    cmd.finish = out_free;
      default:    cmd = '0;
    endcase
  end
endmodule

// File: design/hlc_datapath.sv
// ----------------------------------------------------------------------------
// hlc_datapath: arithmetic and state of the controller
// Shared CORDIC, bit-pair isqrt, one 32x32 multiplier stepped over four products.
// ----------------------------------------------------------------------------
module hlc_datapath #(
  parameter int FRAC_BITS        = 16,
  parameter int COUNT_BITS       = 16,
  parameter int STEPS_PER_SECOND = 60
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hlc_pkg::hlc_cmd_t cmd,
  input  hlc_pkg::hlc_in_t  in_req,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              cfg_we,
  output hlc_pkg::hlc_stat_t stat,
  output hlc_pkg::hlc_out_t result
);
  import hlc_pkg::*;

  localparam int SH = ANG_BITS - FRAC_BITS;
  localparam logic [31:0] JUMP_TICKS = 32'((STEPS_PER_SECOND + 1) / 2);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                             input int k);
    logic signed [63:0] t;
    t = v + (64'sd1 <<< (k - 1));
    return t >>> k;
  endfunction

  logic signed [31:0] regs_r [REG_COUNT];
  hlc_in_t in_r;
  logic signed [63:0] x_r, y_r, z_r;
  logic [4:0] step_r;
  logic signed [63:0] phi_r, phi_rate_r, aim_r, force_r, torque_r;
  logic [63:0] sq_v_r, sq_r_r, sq_b_r;
  logic signed [31:0] last_angle_r;
  logic last_contact_r, jump_armed_r, touch_r;
  logic [COUNT_BITS-1:0] phase_r;
  logic [31:0] jump_left_r;
  logic [1:0] mul_idx_r;
  logic signed [31:0] ma_r [4];
  logic signed [31:0] mb_r [4];
  logic signed [63:0] acc_r;
  logic signed [63:0] mprod;

  // CORDIC / normalize / isqrt combinational helpers
  logic signed [63:0] dx, dy, ax, ay;
  logic need_shift;
  assign dx = x_r >>> step_r;
  assign dy = y_r >>> step_r;
  assign ax = x_r < 0 ? -x_r : x_r;
  assign ay = y_r < 0 ? -y_r : y_r;
  assign need_shift = (x_r != 0 || y_r != 0) && ax < 64'sd1073741824 &&
                      ay < 64'sd1073741824;
  assign stat.norm_done = !need_shift;
  assign stat.cordic_done = (step_r == 5'(CORDIC_STEPS - 1));
  assign stat.sqrt_done = (sq_b_r == 64'd0);
  assign stat.mul_done = (mul_idx_r == 2'd3);
  assign mprod = 64'(ma_r[mul_idx_r]) * 64'(mb_r[mul_idx_r]);

  // clamped aim fits in 30 bits, so the square is a 32x32 product
  logic signed [31:0] aim_n;
  assign aim_n = aim_r[31:0];

  logic signed [63:0] sum_aim, aim_c, setp, err_s, rate_s, tgt, herr;
  logic touch;
  always_comb begin
    touch = in_r.foot_height <= 0;
    sum_aim = 64'(in_r.forward_vel) * $signed(AIM_GAIN_Q30) +
              (64'(in_r.forward_vel) - 64'(regs_r[REG_SPEED])) *
              $signed(SPD_GAIN_Q30);
    aim_c = rnd(sum_aim, FRAC_BITS);
    if (aim_c > $signed(LEG_Q30)) aim_c = $signed(LEG_Q30);
    if (aim_c < -$signed(LEG_Q30)) aim_c = -$signed(LEG_Q30);
    setp = -rnd($signed(REST_Q30), SH);
    if (touch_r && 64'(in_r.spring_pos) > -rnd($signed(PUSH_LIM_Q30), SH))
      setp = setp + 64'(regs_r[REG_PUSH_OFFSET]);
    err_s = sat32(64'(in_r.spring_pos) - setp);
    rate_s = sat32((phi_r - 64'(last_angle_r)) * STEPS_PER_SECOND);
    tgt = rnd(z_r, SH) - phi_r;
    herr = sat32(64'(in_r.hinge_angle) - tgt);
  end

  logic [63:0] sq_rb;
  assign sq_rb = sq_r_r + sq_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[REG_PUSH_OFFSET] <= -32'sd49152;
      regs_r[REG_SPRING_K]    <= 32'sd26214400;
      regs_r[REG_SPRING_D]    <= 32'sd983040;
      regs_r[REG_SPEED]       <= 32'sd13107;
      regs_r[REG_SWING_KP]    <= 32'sd6553600;
      regs_r[REG_SWING_KD]    <= 32'sd327680;
      regs_r[REG_STANCE_KP]   <= -32'sd589824;
      regs_r[REG_STANCE_KD]   <= -32'sd65536;
    end else if (cfg_we) begin
      regs_r[cfg_index] <= cfg_data;
    end
    if (cmd.load) in_r <= in_req;
    if (cmd.prep1) begin
      step_r <= '0;
      aim_r <= aim_c;
      if (in_r.dip_along < 0) begin
        z_r <= in_r.dip_vertical >= 0 ? $signed(PI_Q30) : -$signed(PI_Q30);
        x_r <= -64'(in_r.dip_along);
        y_r <= -64'(in_r.dip_vertical);
      end else begin
        z_r <= '0;
        x_r <= 64'(in_r.dip_along);
        y_r <= 64'(in_r.dip_vertical);
      end
    end
    if (cmd.norm && need_shift) begin
      x_r <= x_r <<< 1;
      y_r <= y_r <<< 1;
    end
    if (cmd.cordic && (x_r != 0 || y_r != 0)) begin
      step_r <= step_r + 5'd1;
      if (y_r >= 0) begin
        x_r <= x_r + dy; y_r <= y_r - dx; z_r <= z_r + atan_entry(step_r);
      end else begin
        x_r <= x_r - dy; y_r <= y_r + dx; z_r <= z_r - atan_entry(step_r);
      end
    end else if (cmd.cordic) begin
      step_r <= step_r + 5'd1;
    end
    if (cmd.aim) begin
      phi_r <= rnd(z_r, SH);
      sq_v_r <= LEG_Q30 * LEG_Q30 - 64'(64'(aim_n) * 64'(aim_n));
      sq_r_r <= '0;
      sq_b_r <= 64'd1 << 62;
    end
    if (cmd.sqrt_step && !stat.sqrt_done) begin
      if (sq_b_r > sq_v_r && sq_r_r == 0) begin
        sq_b_r <= sq_b_r >> 2;
      end else begin
        if (sq_v_r >= sq_rb) begin
          sq_v_r <= sq_v_r - sq_rb;
          sq_r_r <= (sq_r_r >> 1) + sq_b_r;
        end else begin
          sq_r_r <= sq_r_r >> 1;
        end
        sq_b_r <= sq_b_r >> 2;
      end
    end
    if (cmd.prep2) begin
      // side length is nonnegative, so no half-plane fold
      x_r <= $signed(sq_r_r);
      y_r <= aim_r;
      z_r <= '0;
      step_r <= '0;
    end
    if (cmd.law) begin
      mul_idx_r <= '0;
      acc_r <= '0;
      ma_r[0] <= regs_r[REG_SPRING_K];
      mb_r[0] <= err_s[31:0];
      ma_r[1] <= regs_r[REG_SPRING_D];
      mb_r[1] <= in_r.spring_rate;
      if (!touch_r) begin
        ma_r[2] <= regs_r[REG_SWING_KP]; mb_r[2] <= herr[31:0];
        ma_r[3] <= regs_r[REG_SWING_KD]; mb_r[3] <= in_r.hinge_rate;
      end else begin
        ma_r[2] <= regs_r[REG_STANCE_KP]; mb_r[2] <= phi_r[31:0];
        ma_r[3] <= regs_r[REG_STANCE_KD]; mb_r[3] <= rate_s[31:0];
      end
    end
    if (cmd.mul_step) begin
      mul_idx_r <= mul_idx_r + 2'd1;
      case (mul_idx_r)
        2'd0: force_r <= -rnd(mprod, FRAC_BITS);
        2'd1: force_r <= force_r - rnd(mprod, FRAC_BITS);
        2'd2: torque_r <= -rnd(mprod, FRAC_BITS);
        default: torque_r <= torque_r - rnd(mprod, FRAC_BITS);
      endcase
    end
    if (cmd.prep1) touch_r <= touch;
  end

  // Persistent tick state: phase/contact update at prep1, angle/jump at finish.
  logic jump_now;
  logic [31:0] left_now;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_angle_r <= '0;
      last_contact_r <= 1'b0;
      phase_r <= '0;
      jump_armed_r <= 1'b0;
      jump_left_r <= '0;
    end else begin
      if (cmd.prep1) begin
        if (touch == last_contact_r) begin
          if (phase_r != COUNT_MAX) phase_r <= phase_r + 1'b1;
        end else begin
          phase_r <= COUNT_BITS'(1);
          last_contact_r <= touch;
        end
      end
      if (cmd.finish) begin
        last_angle_r <= phi_r[31:0];
        jump_armed_r <= jump_now;
        jump_left_r <= left_now;
      end
    end
  end

  logic signed [63:0] force_f, force_s, torque_s;
  always_comb begin
    jump_now = in_r.jump_toggle ? !jump_armed_r : jump_armed_r;
    left_now = in_r.jump_toggle ? JUMP_TICKS : jump_left_r;
    force_f = force_r;
    if (jump_now && touch_r) begin
      force_f = force_r - (64'sd200 <<< FRAC_BITS);
      if (left_now != 0) left_now = left_now - 32'd1;
      if (left_now == 0) jump_now = 1'b0;
    end
    force_s = sat32(force_f);
    torque_s = sat32(torque_r);
    result.spring_force = force_s[31:0];
    result.hinge_torque = torque_s[31:0];
    result.on_ground = touch_r;
    result.phase_ticks = (COUNT_BITS > 16 && phase_r > COUNT_BITS'(16'hFFFF)) ?
                         16'hFFFF : 16'(phase_r);
    result.jump_active = jump_now;
  end
endmodule

// File: verif/hopper_leg_controller_core_tb.sv
// ----------------------------------------------------------------------------
// hopper_leg_controller_core_tb: self-checking bench for the leg controller
// Walks a short directed stimulus table, then runs random control ticks
// under several gain settings, with random valid gaps and result stalls.
// Every result is checked field by field against a bit-exact predictor or a typed expected value.
// ----------------------------------------------------------------------------
module hopper_leg_controller_core_tb;
  import hlc_pkg::*;

  localparam int     FRAC     = 16;
  localparam int     STEPS    = 60;
  localparam int     ANG_SH   = ANG_BITS - FRAC;
  localparam int     JUMP_TKS = (STEPS + 1) / 2;
  localparam int     MAXI     = 2147483647;
  localparam int     MINI     = -2147483647 - 1;
  localparam int     DOG_MAX  = 5000;
  localparam int     SETTLE   = 150;
  localparam longint PI_C     = longint'(PI_Q30);
  localparam longint LEG_C    = longint'(LEG_Q30);
  localparam longint REST_C   = longint'(REST_Q30);
  localparam longint PLIM_C   = longint'(PUSH_LIM_Q30);
  localparam longint AIMG_C   = longint'(AIM_GAIN_Q30);
  localparam longint SPDG_C   = longint'(SPD_GAIN_Q30);

  // Register defaults after reset
  localparam int DEF_GAIN [0:7] = '{
    -49152, 26214400, 983040, 13107, 6553600, 327680, -589824, -65536
  };

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  hlc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  hlc_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  hopper_leg_controller_core dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Truncated arctangent steps, Q2.30
  localparam longint ATAN_STEP [0:30] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
    127, 63, 31, 15, 8, 4, 2, 1
  };

  // Shadow of the controller: gains and tick history
  longint      gain [0:7];
  longint      angle_prev;
  bit          contact_prev;
  int unsigned phase_cnt;
  bit          jump_on;
  int          jump_left;

  hlc_out_t    pending_ticks[$];
  int          errors = 0;
  int          n_ticks = 0;
  int          n_results = 0;
  int          n_writes = 0;
  bit          calm = 1'b0;
  logic [31:0] next_cfg [0:7];

  // Random run shape: ground/air stretches
  bit          rnd_ground = 1'b0;
  int          rnd_run = 10;

  function automatic longint rnd_shift(longint v, int k);
    if (k == 0) return v;
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic longint clip32(longint v);
    if (v > longint'(MAXI)) return longint'(MAXI);
    if (v < longint'(MINI)) return longint'(MINI);
    return v;
  endfunction

  function automatic longint gmul(longint g, longint v);
    return rnd_shift(g * v, FRAC);
  endfunction

  // Vectoring CORDIC atan2 in Q2.30, with prescale to full magnitude
  function automatic longint vector_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_C : -PI_C;
      x = -x;
      y = -y;
    end
    while (((x < 0) ? -x : x) < (longint'(1) <<< 30) &&
           ((y < 0) ? -y : y) < (longint'(1) <<< 30)) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < 31; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y >= 0) begin
        x = x + dy; y = y - dx; z = z + ATAN_STEP[i];
      end else begin
        x = x - dy; y = y + dx; z = z - ATAN_STEP[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // One control tick: updates the shadow history, returns the result
  function automatic hlc_out_t control_law(hlc_in_t t);
    longint zz, zr, th, thr, fv, dv, da, ft;
    longint phi, phi_rate, set_pt, spring_f, aim, side, reach, target, torque;
    bit touch;
    hlc_out_t r;
    zz = t.spring_pos;   zr = t.spring_rate;
    th = t.hinge_angle;  thr = t.hinge_rate;
    fv = t.forward_vel;  dv = t.dip_vertical;
    da = t.dip_along;    ft = t.foot_height;

    if (t.jump_toggle) begin
      jump_on = !jump_on;
      jump_left = JUMP_TKS;
    end

    phi = rnd_shift(vector_angle(dv, da), ANG_SH);
    phi_rate = clip32((phi - angle_prev) * STEPS);
    angle_prev = phi;

    touch = (ft <= 0);
    if (touch == contact_prev) begin
      if (phase_cnt < 65535) phase_cnt++;
    end else begin
      phase_cnt = 1;
      contact_prev = touch;
    end

    // push-off only while grounded and the spring is not yet compressed far
    set_pt = -rnd_shift(REST_C, ANG_SH);
    if (touch && zz > -rnd_shift(PLIM_C, ANG_SH)) set_pt = set_pt + gain[REG_PUSH_OFFSET];
    spring_f = -gmul(gain[REG_SPRING_K], clip32(zz - set_pt)) -
               gmul(gain[REG_SPRING_D], zr);

    aim = rnd_shift(fv * AIMG_C + (fv - gain[REG_SPEED]) * SPDG_C, FRAC);
    if (aim > LEG_C) aim = LEG_C;
    if (aim < -LEG_C) aim = -LEG_C;
    side = longint'(root_floor(longint'(LEG_C * LEG_C - aim * aim)));
    reach = rnd_shift(vector_angle(aim, side), ANG_SH);
    target = reach - phi;

    if (jump_on && touch) begin
      spring_f = spring_f - (longint'(200) <<< FRAC);
      if (jump_left > 0) jump_left--;
      if (jump_left == 0) jump_on = 1'b0;
    end

    if (!touch)
      torque = -gmul(gain[REG_SWING_KP], clip32(th - target)) - gmul(gain[REG_SWING_KD], thr);
    else
      torque = -gmul(gain[REG_STANCE_KP], phi) - gmul(gain[REG_STANCE_KD], phi_rate);

    r.spring_force = 32'(clip32(spring_f));
    r.hinge_torque = 32'(clip32(torque));
    r.on_ground    = touch;
    r.phase_ticks  = 16'(phase_cnt);
    r.jump_active  = jump_on;
    return r;
  endfunction

  function automatic hlc_in_t mk(int sp, int sr, int ha, int hr, int fv, int dv,
                                 int da, int fh, bit jt);
    hlc_in_t t;
    t.spring_pos = sp;  t.spring_rate = sr; t.hinge_angle = ha; t.hinge_rate = hr;
    t.forward_vel = fv; t.dip_vertical = dv; t.dip_along = da; t.foot_height = fh;
    t.jump_toggle = jt;
    return t;
  endfunction

  function automatic int span(int s);
    return int'($urandom_range(0, 2 * s)) - s;
  endfunction

  // Mostly plausible hopping ticks in ground/air stretches, some raw noise
  function automatic hlc_in_t random_tick();
    hlc_in_t t;
    if ($urandom_range(0, 99) < 15) begin
      t = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom_range(0, 1));
      return t;
    end
    if (rnd_run == 0) begin
      rnd_ground = !rnd_ground;
      rnd_run = $urandom_range(3, 40);
    end
    rnd_run--;
    t = mk(span(32768), span(131072), span(40000), span(200000), span(100000),
           span(20000), 20000 + int'($urandom_range(0, 30000)),
           rnd_ground ? -int'($urandom_range(0, 3000)) : int'($urandom_range(1, 30000)),
           $urandom_range(0, 29) == 0);
    if ($urandom_range(0, 19) == 0) t.dip_along = -t.dip_along;
    if ($urandom_range(0, 29) == 0) t.foot_height = 0;
    return t;
  endfunction

  task automatic idle_cycles();
    int n;
    n = calm ? 0 : $urandom_range(0, 10);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Present one request and hold it until taken; queue its forecast
  task automatic send_tick(hlc_in_t t, bit typed, hlc_out_t want);
    hlc_out_t p;
    idle_cycles();
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    p = control_law(t);
    pending_ticks.push_back(typed ? want : p);
    n_ticks++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_gains();
    for (int i = 0; i < REG_COUNT; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= hlc_reg_t'(i);
      cfg_data  <= next_cfg[i];
      do @(posedge clk); while (!cfg_ready);
      gain[i] = longint'(signed'(next_cfg[i]));
      n_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stall per result, then take the next one
  initial begin
    int n;
    forever begin
      n = calm ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin : check
    hlc_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_ticks.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        e = pending_ticks.pop_front();
        if (out_data.spring_force !== e.spring_force) begin
          $error("spring_force: expected %0d, got %0d", e.spring_force, out_data.spring_force);
          errors++;
        end
        if (out_data.hinge_torque !== e.hinge_torque) begin
          $error("hinge_torque: expected %0d, got %0d", e.hinge_torque, out_data.hinge_torque);
          errors++;
        end
        if (out_data.on_ground !== e.on_ground) begin
          $error("on_ground: expected %0d, got %0d", e.on_ground, out_data.on_ground);
          errors++;
        end
        if (out_data.phase_ticks !== e.phase_ticks) begin
          $error("phase_ticks: expected %0d, got %0d", e.phase_ticks, out_data.phase_ticks);
          errors++;
        end
        if (out_data.jump_active !== e.jump_active) begin
          $error("jump_active: expected %0d, got %0d", e.jump_active, out_data.jump_active);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long with no request, result or write taken
  always @(posedge clk) begin : dog
    int quiet;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= DOG_MAX) begin
      $display("timeout: no handshake for %0d cycles", DOG_MAX);
      $display("hopper_leg_controller_core_tb failed");
      $finish;
    end
  end

  typedef struct {
    hlc_in_t  stim;
    bit       typed;
    hlc_out_t want;
  } row_t;

  initial begin
    row_t     rows[$];
    hlc_out_t none;
    int       count;
    none = '0;

    gain = '{-49152, 26214400, 983040, 13107, 6553600, 327680, -589824, -65536};
    angle_prev = 0; contact_prev = 0; phase_cnt = 0; jump_on = 0; jump_left = 0;

    // Zero tick on the ground right after reset: push-off set point,
    // zero vector angle, fresh ground phase.
    rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                     '{-32'sd22282400, 32'sd0, 1'b1, 16'd1, 1'b0}});
    rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 1, 0), 1'b0, none});
    // field extremes, both signs, with toggles
    rows.push_back('{mk(MAXI, MAXI, MAXI, MAXI, MAXI, MAXI, MAXI, MAXI, 1), 1'b0, none});
    rows.push_back('{mk(MINI, MINI, MINI, MINI, MINI, MINI, MINI, MINI, 1), 1'b0, none});
    // negative dip_along: angle folds to +pi, then flips to near -pi
    rows.push_back('{mk(0, 0, 0, 0, 0, 0, -65536, -1, 0), 1'b0, none});
    rows.push_back('{mk(0, 0, 0, 0, 0, -1, -65536, -1, 0), 1'b0, none});
    rows.push_back('{mk(0, 0, 0, 0, 0, MINI, 0, -1, 0), 1'b0, none});
    // push-off threshold on the ground
    rows.push_back('{mk(-13107, 0, 0, 0, 0, 100, 20000, 0, 0), 1'b0, none});
    rows.push_back('{mk(-13106, 0, 0, 0, 0, 100, 20000, 0, 0), 1'b0, none});
    // aim clamp both ways, hinge error saturation in the air
    rows.push_back('{mk(0, 0, 0, 0, MAXI, 0, 20000, 5, 0), 1'b0, none});
    rows.push_back('{mk(0, 0, 0, 0, MINI, 0, 20000, 5, 0), 1'b0, none});
    rows.push_back('{mk(0, 0, MINI, MAXI, 0, 300, 20000, 5, 0), 1'b0, none});
    rows.push_back('{mk(0, 0, MAXI, MINI, 0, -300, 20000, 5, 0), 1'b0, none});
    // jump on the ground, boost ticks, then toggle off and back on in the air
    rows.push_back('{mk(-1000, 5000, 0, 0, 13107, 50, 20000, -10, 1), 1'b0, none});
    rows.push_back('{mk(-2000, 4000, 0, 0, 13107, 60, 20000, -10, 0), 1'b0, none});
    rows.push_back('{mk(-3000, 3000, 0, 0, 13107, 70, 20000, -10, 0), 1'b0, none});
    rows.push_back('{mk(-1000, -2000, 100, 50, 13107, 80, 20000, 900, 1), 1'b0, none});
    rows.push_back('{mk(-1000, -2000, 100, 50, 13107, 80, 20000, 900, 1), 1'b0, none});
    rows.push_back('{mk(500, 100, 100, 50, 13107, 80, 20000, 0, 0), 1'b0, none});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    calm = 1'b1;
    foreach (rows[i]) send_tick(rows[i].stim, rows[i].typed, rows[i].want);
    drain();

    // gain phases: defaults, random, all max, all min, zero, defaults again
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        case (ph)
          1: next_cfg[i] = $urandom;
          2: next_cfg[i] = MAXI;
          3: next_cfg[i] = MINI;
          4: next_cfg[i] = '0;
          default: next_cfg[i] = 32'(DEF_GAIN[i]);
        endcase
      end
      write_gains();
      calm = (ph == 0);
      count = (ph >= 2 && ph <= 4) ? 50 : 175;
      for (int k = 0; k < count; k++) send_tick(random_tick(), 1'b0, none);
      drain();
    end

    $display("covered %0d ticks, %0d results, %0d register writes over six gain sets",
             n_ticks, n_results, n_writes);
    if (errors == 0)
      $display("hopper_leg_controller_core_tb passed");
    else
      $display("hopper_leg_controller_core_tb failed");
    $finish;
  end

endmodule

// File: sim.f
design/hlc_pkg.sv
design/hlc_ctrl.sv
design/hlc_datapath.sv
design/hopper_leg_controller_core.sv
verif/hopper_leg_controller_core_tb.sv
